// File: rtl/core/paged_bitmap_record_allocator_assert.svh
// Assertion macros shared by the checker of the paged bitmap record allocator.
// Depends on nothing; the using module must provide signals named clock and reset.
`ifndef PAGED_BITMAP_RECORD_ALLOCATOR_ASSERT_SVH
`define PAGED_BITMAP_RECORD_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define PBRA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define PBRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pbra_pkg.sv
// Shared constants, codes and types of the paged bitmap record allocator.
// Depends on nothing; the word unit, the allocator, the checker and the testbench use it by scoped names.
package pbra_pkg;

   localparam int WORD_BITS      = 32;
   localparam int BITS_PER_PAGE  = 4096;
   localparam int PAGE_COUNT     = 8;
   localparam int WORDS_PER_PAGE = BITS_PER_PAGE / WORD_BITS;
   localparam int TOTAL_WORDS    = PAGE_COUNT * WORDS_PER_PAGE;

   localparam int ID_W        = 15;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_ADDR_W = $clog2(TOTAL_WORDS);
   localparam int WPP_W       = $clog2(WORDS_PER_PAGE);
   localparam int PAGE_W      = $clog2(PAGE_COUNT);
   localparam int PAGE_CNT_W  = $clog2(PAGE_COUNT + 1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_ALLOC = 2'd2,
      STATUS_RESERVED  = 2'd3
   } status_type;

   // What the shared word unit reports about one bitmap word.
   typedef struct packed {
      logic                 full;
      logic [BIT_IDX_W-1:0] first_zero;
      logic [WORD_BITS-1:0] set_word;
      logic                 bit_set;
      logic [WORD_BITS-1:0] clr_word;
      logic                 clr_zero;
   } wu_res_type;

endpackage

// File: rtl/core/pbra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pbra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/pbra_word_unit.sv
// Shared word unit: finds the lowest clear bit of a bitmap word and tests or
// clears a selected bit. Depends on pbra_pkg.
module pbra_word_unit (
   input  logic [pbra_pkg::WORD_BITS-1:0] word,
   input  logic [pbra_pkg::BIT_IDX_W-1:0] bit_sel,
   output pbra_pkg::wu_res_type           res
);

   logic [pbra_pkg::WORD_BITS-1:0] low_zero;
   logic [pbra_pkg::WORD_BITS-1:0] sel_mask;
   logic [pbra_pkg::BIT_IDX_W-1:0] first_zero;

   // Adding one ripples through the trailing ones, so this leaves only the
   // lowest clear bit set.
   assign low_zero = ~word & (word + {{(pbra_pkg::WORD_BITS-1){1'b0}}, 1'b1});
   assign sel_mask = {{(pbra_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;

   always_comb begin
      first_zero = '0;
      for (int b = 0; b < pbra_pkg::WORD_BITS; b++) begin
         if (low_zero[b]) begin
            first_zero = first_zero | pbra_pkg::BIT_IDX_W'(b);
         end
      end
   end

   always_comb begin
      res.full       = &word;
      res.first_zero = first_zero;
      res.set_word   = word | low_zero;
      res.bit_set    = |(word & sel_mask);
      res.clr_word   = word & ~sel_mask;
      res.clr_zero   = (word & ~sel_mask) == '0;
   end

endmodule

// File: rtl/core/paged_bitmap_record_allocator.sv
// Paged bitmap record allocator: hands out and takes back 15-bit record
// numbers from a 1024 x 32 bitmap RAM split into eight pages of 4096 records,
// with record 0 reserved. After reset the block sweeps the RAM once, one word
// a cycle, and holds req_ready low for the whole sweep. A free in an open page
// tests and writes back its bitmap word in one state and hands the result off
// in the next; a free of record 0 or of an unopened page goes straight to the
// hand-off. The block can take the next request word once the hand-off is done.
// An allocate is a first-fit scan that streams one bitmap word per cycle
// through the shared word unit; it ends at the first word with room, or opens
// a new page, or reports full, when every open page is full. One request is in
// work at a time; a finished result sits in the output register while the next
// request is taken.
// Depends on pbra_pkg, pbra_ram and pbra_word_unit.
module paged_bitmap_record_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [pbra_pkg::ID_W-1:0] req_record_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [pbra_pkg::ID_W-1:0] rsp_granted_id,
   output logic [1:0]                rsp_status,
   output logic                      rsp_page_opened,
   output logic                      rsp_group_emptied
);

   localparam int AW = pbra_pkg::WORD_ADDR_W;

   typedef enum logic [4:0] {
      ST_INIT     = 5'b00001,
      ST_IDLE     = 5'b00010,
      ST_SCAN     = 5'b00100,
      ST_FREE_CHK = 5'b01000,
      ST_RESULT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]                     init_addr_ff, init_addr_in;
   logic [pbra_pkg::PAGE_CNT_W-1:0]   open_cnt_ff, open_cnt_in;
   logic [AW:0]                       scan_addr_ff, scan_addr_in;
   logic                              chk_valid_ff, chk_valid_in;
   logic [AW-1:0]                     chk_addr_ff, chk_addr_in;
   logic [AW-1:0]                     free_addr_ff, free_addr_in;
   logic [pbra_pkg::BIT_IDX_W-1:0]    free_bit_ff, free_bit_in;

   logic [pbra_pkg::ID_W-1:0]         res_id_ff, res_id_in;
   pbra_pkg::status_type              res_status_ff, res_status_in;
   logic                              res_opened_ff, res_opened_in;
   logic                              res_emptied_ff, res_emptied_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pbra_pkg::ID_W-1:0]         rsp_id_ff, rsp_id_in;
   pbra_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                              rsp_opened_ff, rsp_opened_in;
   logic                              rsp_emptied_ff, rsp_emptied_in;

   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [pbra_pkg::WORD_BITS-1:0]    wr_data;
   logic [AW-1:0]                     rd_addr;
   logic [pbra_pkg::WORD_BITS-1:0]    rd_data;

   pbra_pkg::wu_res_type              wu_res;

   logic [AW:0]                       scan_end;
   logic                              issue;
   logic [pbra_pkg::PAGE_W-1:0]       req_page;
   logic [AW-1:0]                     new_page_base;

   pbra_ram #(
      .WIDTH (pbra_pkg::WORD_BITS),
      .DEPTH (pbra_pkg::TOTAL_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The word unit always looks at the word the RAM just returned. The scan
   // uses its first-clear-bit output; a free uses its selected-bit outputs.
   pbra_word_unit u_word_unit (
      .word    (rd_data),
      .bit_sel (free_bit_ff),
      .res     (wu_res)
   );

   // Pages open strictly in order, so a count of open pages stands for the
   // per-page open flags. The scan covers every word of the open pages.
   assign scan_end      = {open_cnt_ff, {pbra_pkg::WPP_W{1'b0}}};
   assign issue         = scan_addr_ff < scan_end;
   assign req_page      = req_record_id[pbra_pkg::ID_W-1 -: pbra_pkg::PAGE_W];
   assign new_page_base = {open_cnt_ff[pbra_pkg::PAGE_W-1:0], {pbra_pkg::WPP_W{1'b0}}};

   always_comb begin
      state_in       = state_ff;
      init_addr_in   = init_addr_ff;
      open_cnt_in    = open_cnt_ff;
      scan_addr_in   = scan_addr_ff;
      chk_valid_in   = chk_valid_ff;
      chk_addr_in    = chk_addr_ff;
      free_addr_in   = free_addr_ff;
      free_bit_in    = free_bit_ff;
      res_id_in      = res_id_ff;
      res_status_in  = res_status_ff;
      res_opened_in  = res_opened_ff;
      res_emptied_in = res_emptied_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_id_in      = rsp_id_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_opened_in  = rsp_opened_ff;
      rsp_emptied_in = rsp_emptied_ff;
      wr_en          = 1'b0;
      wr_addr        = init_addr_ff;
      wr_data        = '0;
      rd_addr        = req_record_id[pbra_pkg::ID_W-1 -: AW];

      case (state_ff)
         ST_INIT: begin
            // Clearing sweep: every word goes to zero except word 0, whose
            // bit 0 marks the reserved record.
            wr_en        = 1'b1;
            wr_addr      = init_addr_ff;
            wr_data      = (init_addr_ff == '0) ? pbra_pkg::WORD_BITS'(1) : '0;
            init_addr_in = init_addr_ff + AW'(1);
            if (init_addr_ff == AW'(pbra_pkg::TOTAL_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // The read address follows the request, so a free has its word
            // ready in the next cycle.
            if (req_valid) begin
               res_id_in      = '0;
               res_opened_in  = 1'b0;
               res_emptied_in = 1'b0;
               free_addr_in   = req_record_id[pbra_pkg::ID_W-1 -: AW];
               free_bit_in    = req_record_id[pbra_pkg::BIT_IDX_W-1:0];
               if (req_op == pbra_pkg::OP_ALLOC) begin
                  scan_addr_in = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end else if (req_record_id == '0) begin
                  res_status_in = pbra_pkg::STATUS_RESERVED;
                  state_in      = ST_RESULT;
               end else if ({1'b0, req_page} >= open_cnt_ff) begin
                  res_status_in = pbra_pkg::STATUS_NOT_ALLOC;
                  state_in      = ST_RESULT;
               end else begin
                  state_in = ST_FREE_CHK;
               end
            end
         end

         ST_SCAN: begin
            // One word address goes out each cycle while the word read in the
            // cycle before is checked.
            rd_addr = scan_addr_ff[AW-1:0];
            if (chk_valid_ff && !wu_res.full) begin
               wr_en         = 1'b1;
               wr_addr       = chk_addr_ff;
               wr_data       = wu_res.set_word;
               res_id_in     = {chk_addr_ff, wu_res.first_zero};
               res_status_in = pbra_pkg::STATUS_OK;
               state_in      = ST_RESULT;
            end else if (!chk_valid_ff && !issue) begin
               // Every open page is full. A page never opened before still
               // holds the zeros of the reset sweep, so opening it only has
               // to mark its first record.
               if (open_cnt_ff < pbra_pkg::PAGE_CNT_W'(pbra_pkg::PAGE_COUNT)) begin
                  wr_en         = 1'b1;
                  wr_addr       = new_page_base;
                  wr_data       = pbra_pkg::WORD_BITS'(1);
                  open_cnt_in   = open_cnt_ff + pbra_pkg::PAGE_CNT_W'(1);
                  res_id_in     = {new_page_base, {pbra_pkg::BIT_IDX_W{1'b0}}};
                  res_status_in = pbra_pkg::STATUS_OK;
                  res_opened_in = 1'b1;
               end else begin
                  res_status_in = pbra_pkg::STATUS_FULL;
               end
               state_in = ST_RESULT;
            end else begin
               chk_valid_in = issue;
               chk_addr_in  = scan_addr_ff[AW-1:0];
               if (issue) begin
                  scan_addr_in = scan_addr_ff + (AW + 1)'(1);
               end
            end
         end

         ST_FREE_CHK: begin
            if (!wu_res.bit_set) begin
               res_status_in = pbra_pkg::STATUS_NOT_ALLOC;
            end else begin
               wr_en          = 1'b1;
               wr_addr        = free_addr_ff;
               wr_data        = wu_res.clr_word;
               res_status_in  = pbra_pkg::STATUS_OK;
               res_emptied_in = wu_res.clr_zero;
            end
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_id_in      = res_id_ff;
               rsp_status_in  = res_status_ff;
               rsp_opened_in  = res_opened_ff;
               rsp_emptied_in = res_emptied_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_addr_ff <= '0;
         open_cnt_ff  <= pbra_pkg::PAGE_CNT_W'(1);
         scan_addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         open_cnt_ff  <= open_cnt_in;
         scan_addr_ff <= scan_addr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff    <= chk_addr_in;
      free_addr_ff   <= free_addr_in;
      free_bit_ff    <= free_bit_in;
      res_id_ff      <= res_id_in;
      res_status_ff  <= res_status_in;
      res_opened_ff  <= res_opened_in;
      res_emptied_ff <= res_emptied_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_opened_ff  <= rsp_opened_in;
      rsp_emptied_ff <= rsp_emptied_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_id    = rsp_id_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_opened   = rsp_opened_ff;
   assign rsp_group_emptied = rsp_emptied_ff;

endmodule

// File: rtl/core/pbra_checker.sv
// Port-level checker for the paged bitmap record allocator, bound to the top.
// Depends on pbra_pkg and paged_bitmap_record_allocator_assert.svh.
`include "paged_bitmap_record_allocator_assert.svh"

module pbra_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_op,
   input logic [pbra_pkg::ID_W-1:0] req_record_id,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [pbra_pkg::ID_W-1:0] rsp_granted_id,
   input logic [1:0]                rsp_status,
   input logic                      rsp_page_opened,
   input logic                      rsp_group_emptied
);

   // The clearing sweep keeps requests out right after reset.
   `PBRA_ASSERT_IMPL(a_no_ready_after_reset, $past(reset), !req_ready, "ready during sweep")

   // A stalled result word holds still.
   `PBRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status) && $stable(rsp_page_opened) && $stable(rsp_group_emptied), "result word changed while stalled")

   // A failed request carries no record number and no flags.
   `PBRA_ASSERT_IMPL(a_id_zero_on_fail, rsp_valid && rsp_status != pbra_pkg::STATUS_OK, rsp_granted_id == '0 && !rsp_page_opened && !rsp_group_emptied, "failure word carries data")

   // A newly opened page hands out its first record.
   `PBRA_ASSERT_IMPL(a_page_first, rsp_valid && rsp_page_opened, rsp_status == pbra_pkg::STATUS_OK && (rsp_granted_id & pbra_pkg::ID_W'(pbra_pkg::BITS_PER_PAGE - 1)) == '0 && rsp_granted_id != '0, "opened page grant not page aligned")

   // An emptied group comes only from a successful free.
   `PBRA_ASSERT_IMPL(a_empty_on_free, rsp_valid && rsp_group_emptied, rsp_status == pbra_pkg::STATUS_OK && rsp_granted_id == '0 && !rsp_page_opened, "group empty flag on non-free word")

endmodule

bind paged_bitmap_record_allocator pbra_checker u_pbra_checker (.*);

// File: tb/paged_bitmap_record_allocator_tb.sv
// Self-checking testbench for the paged bitmap record allocator.
// Depends on pbra_pkg and paged_bitmap_record_allocator, which in turn needs pbra_ram and pbra_word_unit.
// An in-bench shadow of the bitmap predicts every response word in order of acceptance.
module paged_bitmap_record_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog is far above the slowest run of this stimulus. Roughly 650 request
   // words could each take a full first-fit scan plus long receiver stalls. The initial
   // RAM sweep fits easily within it.
   localparam int CYCLE_LIMIT = 8_000_000;
   // After the last response, wait out more than one worst-case allocate scan, so that
   // a stray response word would still be seen.
   localparam int TAIL_CYCLES = 1100;
   localparam int MAX_REPORTS = 10;

   // One predicted response word.
   typedef struct packed {
      logic [pbra_pkg::ID_W-1:0] granted_id;
      pbra_pkg::status_type      status;
      logic                      page_opened;
      logic                      group_emptied;
   } outcome_type;

   // Every input of the block is known from time zero.
   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_op            = pbra_pkg::OP_ALLOC;
   logic [pbra_pkg::ID_W-1:0] req_record_id     = '0;
   logic                      rsp_ready         = 1'b0;
   logic                      req_ready;
   logic                      rsp_valid;
   logic [pbra_pkg::ID_W-1:0] rsp_granted_id;
   logic [1:0]                rsp_status;
   logic                      rsp_page_opened;
   logic                      rsp_group_emptied;

   // Shadow of the bitmap RAM and of the page-open flags, updated as each request word
   // is accepted.
   logic [pbra_pkg::WORD_BITS-1:0]  bitmap_shadow [pbra_pkg::TOTAL_WORDS];
   logic [pbra_pkg::PAGE_COUNT-1:0] pages_open;

   // Predicted response words that have not arrived yet, oldest first.
   outcome_type               pending_outcomes [$];
   // Record numbers that the shadow says are currently handed out.
   logic [pbra_pkg::ID_W-1:0] held_ids [$];

   int mismatch_count = 0;
   int cycles_run     = 0;
   // Chance in percent that each side idles in a given cycle.
   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   // While nonzero, the receiver holds rsp_ready low and counts this down once a cycle.
   int hold_left      = 0;

   paged_bitmap_record_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_record_id     (req_record_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_id    (rsp_granted_id),
      .rsp_status        (rsp_status),
      .rsp_page_opened   (rsp_page_opened),
      .rsp_group_emptied (rsp_group_emptied)
   );

   always #5 clock = ~clock;

   // Predicts the response word to one request and applies its effect to the shadow.
   function automatic outcome_type compute_outcome(input logic op,
                                                   input logic [pbra_pkg::ID_W-1:0] id);
      outcome_type                    o;
      int                             page;
      int                             w;
      int                             b;
      int                             idx;
      int                             grant;
      logic [pbra_pkg::WORD_BITS-1:0] word;
      bit                             done;
      o.granted_id    = '0;
      o.status        = pbra_pkg::STATUS_OK;
      o.page_opened   = 1'b0;
      o.group_emptied = 1'b0;
      done            = 1'b0;
      if (op == pbra_pkg::OP_ALLOC) begin
         // First fit: walk the open pages in order, skip full bitmap words, and take
         // the lowest clear bit of the first word that has one.
         page = 0;
         while (!done && page < pbra_pkg::PAGE_COUNT && pages_open[page]) begin
            for (w = 0; w < pbra_pkg::WORDS_PER_PAGE && !done; w++) begin
               idx  = page * pbra_pkg::WORDS_PER_PAGE + w;
               word = bitmap_shadow[idx];
               if (word != '1) begin
                  for (b = 0; b < pbra_pkg::WORD_BITS; b++) begin
                     if (!word[b]) break;
                  end
                  grant = page * pbra_pkg::BITS_PER_PAGE + w * pbra_pkg::WORD_BITS + b;
                  done  = 1'b1;
                  if (grant >= (1 << pbra_pkg::ID_W)) begin
                     o.status = pbra_pkg::STATUS_FULL;
                  end else begin
                     bitmap_shadow[idx][b] = 1'b1;
                     o.granted_id          = pbra_pkg::ID_W'(grant);
                  end
               end
            end
            if (!done) page++;
         end
         // Every open page is full: open the next one, if any is left, and hand out its first record.
         if (!done) begin
            grant = page * pbra_pkg::BITS_PER_PAGE;
            if (page >= pbra_pkg::PAGE_COUNT || grant >= (1 << pbra_pkg::ID_W)) begin
               o.status = pbra_pkg::STATUS_FULL;
            end else begin
               for (w = 0; w < pbra_pkg::WORDS_PER_PAGE; w++)
                  bitmap_shadow[page * pbra_pkg::WORDS_PER_PAGE + w] = '0;
               bitmap_shadow[page * pbra_pkg::WORDS_PER_PAGE] = 1;
               pages_open[page] = 1'b1;
               o.granted_id     = pbra_pkg::ID_W'(grant);
               o.page_opened    = 1'b1;
            end
         end
      end else if (id == '0) begin
         o.status = pbra_pkg::STATUS_RESERVED;
      end else begin
         page = int'(id) / pbra_pkg::BITS_PER_PAGE;
         if (page >= pbra_pkg::PAGE_COUNT || !pages_open[page]) begin
            o.status = pbra_pkg::STATUS_NOT_ALLOC;
         end else begin
            idx = page * pbra_pkg::WORDS_PER_PAGE +
                  (int'(id) % pbra_pkg::BITS_PER_PAGE) / pbra_pkg::WORD_BITS;
            b   = int'(id) % pbra_pkg::WORD_BITS;
            if (!bitmap_shadow[idx][b]) begin
               o.status = pbra_pkg::STATUS_NOT_ALLOC;
            end else begin
               bitmap_shadow[idx][b] = 1'b0;
               o.group_emptied       = (bitmap_shadow[idx] == '0);
            end
         end
      end
      return o;
   endfunction

   // Offers one request word. An optional random gap comes first. The task returns at the
   // rising edge that accepts the word, with req_valid still high, so a call that follows at
   // once without a gap keeps valid up and only changes the payload at the next falling edge.
   task automatic send_word(input logic op, input logic [pbra_pkg::ID_W-1:0] id);
      outcome_type o;
      int          pos [$];
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_record_id <= id;
      do @(posedge clock); while (!req_ready);
      o = compute_outcome(op, id);
      pending_outcomes.push_back(o);
      // Keep the list of handed-out records in step, so that later frees can aim at them.
      if (o.status == pbra_pkg::STATUS_OK) begin
         if (op == pbra_pkg::OP_ALLOC) begin
            held_ids.push_back(o.granted_id);
         end else begin
            pos = held_ids.find_first_index(x) with (x == id);
            if (pos.size() != 0) held_ids.delete(pos[0]);
         end
      end
   endtask

   // Receiver: a long hold when a test asks for one, and otherwise random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Each accepted response word is checked against the oldest prediction, field by field.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected response word: id %0d status %0d opened %b emptied %b",
                        $realtime, rsp_granted_id, rsp_status, rsp_page_opened,
                        rsp_group_emptied);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_granted_id !== want.granted_id || rsp_status !== want.status ||
                rsp_page_opened !== want.page_opened ||
                rsp_group_emptied !== want.group_emptied) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: response word mismatch: expected id %0d status %0d ",
                            "opened %b emptied %b, got id %0d status %0d opened %b emptied %b"},
                           $realtime, want.granted_id, want.status, want.page_opened,
                           want.group_emptied, rsp_granted_id, rsp_status, rsp_page_opened,
                           rsp_group_emptied);
            end
         end
      end
   end

   // Boundary cases: the reserved record, frees in closed pages and of clear bits, the
   // extremes of record_id, double frees, and first fit refilling a hole.
   task automatic test_directed();
      send_word(pbra_pkg::OP_FREE, '0);
      send_word(pbra_pkg::OP_FREE, '1);
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(pbra_pkg::BITS_PER_PAGE));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(5));
      // The record_id of an allocate carries junk and must not matter.
      send_word(pbra_pkg::OP_ALLOC, '1);
      send_word(pbra_pkg::OP_ALLOC, '0);
      send_word(pbra_pkg::OP_ALLOC, pbra_pkg::ID_W'('h2aaa));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(2));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(2));
      send_word(pbra_pkg::OP_ALLOC, pbra_pkg::ID_W'('h5555));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(1));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(3));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(31));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(32));
      send_word(pbra_pkg::OP_ALLOC, pbra_pkg::ID_W'(0));
      send_word(pbra_pkg::OP_FREE, pbra_pkg::ID_W'(pbra_pkg::BITS_PER_PAGE - 1));
   endtask

   // Fill the second group word completely, then free its 32 records in random order.
   // Only the last free may report the group as emptied.
   task automatic test_group_drain();
      logic [pbra_pkg::ID_W-1:0] ids [$];
      int                        k;
      int                        pick;
      while (bitmap_shadow[1] != '1)
         send_word(pbra_pkg::OP_ALLOC, pbra_pkg::ID_W'($urandom));
      for (k = pbra_pkg::WORD_BITS; k < 2 * pbra_pkg::WORD_BITS; k++)
         ids.push_back(pbra_pkg::ID_W'(k));
      while (ids.size() != 0) begin
         pick = $urandom_range(ids.size() - 1);
         send_word(pbra_pkg::OP_FREE, ids[pick]);
         ids.delete(pick);
      end
   endtask

   // Mostly allocates and frees of records that are held, with some noise: frees of
   // record 0, of the top record, of random records and of low records that may be clear.
   task automatic test_random_mix(input int count);
      int                        n;
      int                        r;
      int                        pick;
      logic [pbra_pkg::ID_W-1:0] id;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 48) begin
            send_word(pbra_pkg::OP_ALLOC, pbra_pkg::ID_W'($urandom));
         end else if (r < 85 && held_ids.size() != 0) begin
            pick = $urandom_range(held_ids.size() - 1);
            send_word(pbra_pkg::OP_FREE, held_ids[pick]);
         end else begin
            case ($urandom_range(4))
               0: id = '0;
               1: id = '1;
               2: id = pbra_pkg::ID_W'($urandom_range(255));
               default: id = pbra_pkg::ID_W'($urandom);
            endcase
            send_word(pbra_pkg::OP_FREE, id);
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering words.
   // The block must fill up and push back on req_ready without losing anything.
   task automatic test_backpressure();
      int n;
      hold_left = 400;
      for (n = 0; n < 12; n++)
         send_word((n % 2 == 0) ? pbra_pkg::OP_ALLOC : pbra_pkg::OP_FREE,
                   pbra_pkg::ID_W'($urandom_range(127)));
   endtask

   // The sender goes quiet until every response word is home, then starts again from an
   // idle block.
   task automatic test_drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      send_word(pbra_pkg::OP_ALLOC, '0);
      send_word(pbra_pkg::OP_FREE, held_ids[held_ids.size() - 1]);
      send_word(pbra_pkg::OP_ALLOC, '1);
   endtask

   // Watchdog: ends the run as failed if it does not finish in time.
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      // The shadow starts as the block does after reset: record 0 taken, page 0 open.
      foreach (bitmap_shadow[i]) bitmap_shadow[i] = '0;
      bitmap_shadow[0] = 1;
      pages_open       = pbra_pkg::PAGE_COUNT'(1);

      // Reset is held from time zero and released at a falling edge. The block then sweeps its
      // RAM with req_ready low, and the first request word simply waits for it.
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // First phase: the sender idles lightly and the receiver heavily.
      send_idle_pct = 12;
      rsp_idle_pct  = 75;
      test_directed();
      test_group_drain();
      test_random_mix(200);

      // Second phase: the other way round.
      send_idle_pct = 75;
      rsp_idle_pct  = 12;
      test_backpressure();
      test_random_mix(150);

      // Third phase: neither side idles.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_drain_pause();
      test_random_mix(180);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
